// ===== rtl/saq_pkg.sv =====
// Shared types and constants for the stable argsort queue.
`timescale 1ns / 1ps
package saq_pkg;

  localparam int unsigned MaxItemsDefault = 1024;
  localparam int unsigned HeightW         = 16;
  localparam int unsigned PosW            = 11;
  localparam logic [PosW-1:0] PosMax      = 11'd2047;

  localparam logic OpPush = 1'b0;
  localparam logic OpPop  = 1'b1;

  typedef enum logic [1:0] {
    RES_PUSH,
    RES_DROP,
    RES_EMPTY,
    RES_POP
  } res_kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic      push;      // append the request height
    logic      rd_start;  // load read pointer (0 or best+1)
    logic      rd_base;   // 0: scan from zero, 1: shift from best+1
    logic      rd_run;    // issue reads while entries remain
    logic      scan;      // compare returning data against best
    logic      shift;     // write returning data one slot down
    logic      commit;    // remove the popped entry
    logic      emit;      // load the result register
    res_kind_e kind;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic last_data;  // data of the final entry is returning
    logic best_last;  // the minimum is the final entry
  } status_t;

endpackage

// ===== rtl/saq_if.sv =====
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface saq_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] height;
  modport source (output valid, output opcode, output height, input ready);
  modport sink (input valid, input opcode, input height, output ready);
endinterface

interface saq_rsp_if;
  logic        valid;
  logic        ready;
  logic [10:0] orig_position;
  logic        is_last;
  logic        was_empty;
  logic        was_dropped;
  modport source (output valid, output orig_position, output is_last,
                  output was_empty, output was_dropped, input ready);
  modport sink (input valid, input orig_position, input is_last,
                input was_empty, input was_dropped, output ready);
endinterface

// ===== rtl/saq_datapath.sv =====
// Entry memory, counters, minimum scan and compaction for the argsort queue.
`timescale 1ns / 1ps
module saq_datapath #(
  parameter int unsigned MAX_ITEMS = saq_pkg::MaxItemsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  saq_pkg::cmd_t                cmd_i,
  input  logic [saq_pkg::HeightW-1:0]  height_i,
  output saq_pkg::status_t             status_o,
  output logic [saq_pkg::PosW-1:0]     orig_position_o,
  output logic                         is_last_o,
  output logic                         was_empty_o,
  output logic                         was_dropped_o
);
  import saq_pkg::*;

  localparam int unsigned IdxW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned EntW = HeightW + PosW;

  logic [EntW-1:0] mem_q [MAX_ITEMS];

  logic [CntW-1:0]    count_q, count_d;
  logic [PosW-1:0]    npos_q, npos_d;
  logic [CntW-1:0]    rd_idx_q, rd_idx_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]    dat_idx_q;
  logic [EntW-1:0]    rd_data_q;
  logic [IdxW-1:0]    best_idx_q;
  logic [HeightW-1:0] best_h_q;
  logic [PosW-1:0]    best_pos_q;
  logic               rd_more, rd_fire, wr_en, take_best;
  logic [IdxW-1:0]    wr_addr;
  logic [EntW-1:0]    wr_data;
  logic [CntW-1:0]    count_m1;

  assign count_m1 = count_q - CntW'(1);
  assign rd_more  = rd_idx_q < count_q;
  assign rd_fire  = cmd_i.rd_run && rd_more;

  assign status_o.empty     = (count_q == '0);
  assign status_o.full      = (count_q == CntW'(MAX_ITEMS));
  assign status_o.last_data = rd_vld_q && (CntW'(dat_idx_q) == count_m1);
  assign status_o.best_last = (CntW'(best_idx_q) == count_m1);

  // Select write port: append on push, move down during compaction
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[IdxW-1:0];
    wr_data = {height_i, npos_d};
    if (cmd_i.push) begin
      wr_en = 1'b1;
    end else if (cmd_i.shift && rd_vld_q) begin
      wr_en   = 1'b1;
      wr_addr = dat_idx_q - IdxW'(1);
      wr_data = rd_data_q;
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_idx_q[IdxW-1:0]];
    dat_idx_q <= rd_idx_q[IdxW-1:0];
  end

  // Next values of counters and read pointer
  always_comb begin
    count_d  = count_q;
    npos_d   = npos_q;
    rd_idx_d = rd_idx_q;
    rd_vld_d = rd_fire;
    if (cmd_i.push) begin
      count_d = count_q + CntW'(1);
      if (npos_q < PosMax) begin
        npos_d = npos_q + PosW'(1);
      end
    end
    if (cmd_i.commit) begin
      count_d = count_m1;
      if (count_q == CntW'(1)) begin
        npos_d = '0;
      end
    end
    if (cmd_i.rd_start) begin
      rd_idx_d = cmd_i.rd_base ? (CntW'(best_idx_q) + CntW'(1)) : '0;
    end else if (rd_fire) begin
      rd_idx_d = rd_idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      npos_q   <= '0;
      rd_idx_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      npos_q   <= npos_d;
      rd_idx_q <= rd_idx_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // Track first minimum; strict less-than keeps earlier arrivals ahead
  assign take_best = cmd_i.scan && rd_vld_q &&
                     ((dat_idx_q == '0) || (rd_data_q[EntW-1:PosW] < best_h_q));

  always_ff @(posedge clk_i) begin
    if (take_best) begin
      best_idx_q <= dat_idx_q;
      best_h_q   <= rd_data_q[EntW-1:PosW];
      best_pos_q <= rd_data_q[PosW-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      orig_position_o <= '0;
      is_last_o       <= 1'b0;
      was_empty_o     <= 1'b0;
      was_dropped_o   <= 1'b0;
      case (cmd_i.kind)
        RES_PUSH:  ;
        RES_DROP:  was_dropped_o <= 1'b1;
        RES_EMPTY: was_empty_o <= 1'b1;
        RES_POP: begin
          orig_position_o <= best_pos_q;
          is_last_o       <= (count_q == CntW'(1));
        end
        default:   ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ITEMS))
    else $error("entry count above capacity");
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !status_o.full)
    else $error("push into full store");
  a_commit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (count_q != '0) && (CntW'(best_idx_q) < count_q))
    else $error("removal with no valid minimum");
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> CntW'(dat_idx_q) < count_q)
    else $error("returned data beyond stored entries");
`endif

endmodule

// ===== rtl/saq_ctrl.sv =====
// Sequencing state machine for the argsort queue.
`timescale 1ns / 1ps
module saq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_opcode_i,
  output logic             req_ready_o,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  input  saq_pkg::status_t status_i,
  output saq_pkg::cmd_t    cmd_o
);
  import saq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_INIT,
    S_SHIFT,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   accept;

  assign req_ready_o = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready_i);
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;

  // Decode state into datapath commands
  always_comb begin
    cmd_o       = '0;
    cmd_o.kind  = RES_PUSH;
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_opcode_i == OpPush) begin
            cmd_o.push  = !status_i.full;
            cmd_o.emit  = 1'b1;
            cmd_o.kind  = status_i.full ? RES_DROP : RES_PUSH;
            rsp_valid_d = 1'b1;
          end else if (status_i.empty) begin
            cmd_o.emit  = 1'b1;
            cmd_o.kind  = RES_EMPTY;
            rsp_valid_d = 1'b1;
          end else begin
            cmd_o.rd_start = 1'b1;
            state_d        = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.rd_run = 1'b1;
        cmd_o.scan   = 1'b1;
        if (status_i.last_data) begin
          state_d = S_SHIFT_INIT;
        end
      end
      S_SHIFT_INIT: begin
        cmd_o.rd_start = 1'b1;
        cmd_o.rd_base  = 1'b1;
        state_d        = status_i.best_last ? S_COMMIT : S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.rd_run = 1'b1;
        cmd_o.shift  = 1'b1;
        if (status_i.last_data) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        cmd_o.emit   = 1'b1;
        cmd_o.kind   = RES_POP;
        rsp_valid_d  = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule

// ===== rtl/stable_argsort_queue_core.sv =====
// Top level of the stable argsort queue.
//
//  channel  dir  handshake     payload
//  req_i    in   valid/ready   opcode, height
//  rsp_o    out  valid/ready   orig_position, is_last, was_empty, was_dropped
//
// A push or a pop on an empty store needs no memory pass; its result shows next cycle.
// A pop makes two passes over the entry memory (one read and one write port):
// one pass finds the minimum, a second moves any later entries down one slot.
// A new request is taken only once the previous result has been or is being taken.
// Reset clears count and position numbering; the memory needs no clearing.
`timescale 1ns / 1ps
module stable_argsort_queue_core #(
  parameter int unsigned MAX_ITEMS = saq_pkg::MaxItemsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  saq_req_if.sink   req_i,
  saq_rsp_if.source rsp_o
);
  import saq_pkg::*;

  cmd_t    cmd;
  status_t status;

  saq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_opcode_i (req_i.opcode),
    .req_ready_o  (req_i.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  saq_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .height_i        (req_i.height),
    .status_o        (status),
    .orig_position_o (rsp_o.orig_position),
    .is_last_o       (rsp_o.is_last),
    .was_empty_o     (rsp_o.was_empty),
    .was_dropped_o   (rsp_o.was_dropped)
  );

endmodule

// ===== tb/stable_argsort_queue_core_tb.sv =====
// Testbench for the stable argsort queue: directed and random push/pop requests checked against a predictor.
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the store and predicts one result per request
class argsort_scoreboard;
  int unsigned           cap;
  logic [15:0]           heights[$];
  logic [10:0]           positions[$];
  logic [10:0]           last_pos;
  logic [13:0]           expected_results[$];
  int unsigned           errors;

  function new(int unsigned cap_items);
    cap = cap_items;
    last_pos = '0;
    errors = 0;
  endfunction

  // Update the store for one accepted request and queue its result
  function void note_request(logic op, logic [15:0] h);
    int unsigned best;
    logic [10:0] pos;
    logic        last;
    best = 0;
    if (op == saq_pkg::OpPush) begin
      if (heights.size() >= cap) begin
        expected_results.push_back({11'd0, 1'b0, 1'b0, 1'b1});
      end else begin
        if (last_pos < saq_pkg::PosMax) last_pos++;
        heights.push_back(h);
        positions.push_back(last_pos);
        expected_results.push_back({11'd0, 1'b0, 1'b0, 1'b0});
      end
    end else if (heights.size() == 0) begin
      expected_results.push_back({11'd0, 1'b0, 1'b1, 1'b0});
    end else begin
      // First minimum in arrival order keeps ties stable
      for (int unsigned i = 1; i < heights.size(); i++)
        if (heights[i] < heights[best]) best = i;
      pos = positions[best];
      heights.delete(best);
      positions.delete(best);
      last = (heights.size() == 0);
      if (last) last_pos = '0;
      expected_results.push_back({pos, last, 1'b0, 1'b0});
    end
  endfunction

  // Compare one accepted result with the oldest expectation
  function void check_result(logic [10:0] pos, logic last, logic empty, logic dropped);
    logic [13:0] exp_r;
    if (expected_results.size() == 0) begin
      $error("result with no request outstanding: pos=%0d", pos);
      errors++;
      return;
    end
    exp_r = expected_results.pop_front();
    if (pos !== exp_r[13:3]) begin
      $error("orig_position expected %0d actual %0d", exp_r[13:3], pos);
      errors++;
    end
    if (last !== exp_r[2]) begin
      $error("is_last expected %0b actual %0b", exp_r[2], last);
      errors++;
    end
    if (empty !== exp_r[1]) begin
      $error("was_empty expected %0b actual %0b", exp_r[1], empty);
      errors++;
    end
    if (dropped !== exp_r[0]) begin
      $error("was_dropped expected %0b actual %0b", exp_r[0], dropped);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_results.size();
  endfunction
endclass

module stable_argsort_queue_core_tb;
  localparam int unsigned Cap = saq_pkg::MaxItemsDefault;
  // A pop on a full store runs two passes over the memory, plus both idle gaps
  localparam int unsigned StallLimit = 8 * Cap + 1000;

  logic clk_i;
  logic rst_ni;
  bit   no_idle;
  int unsigned quiet_cycles;
  int unsigned gen_count;

  saq_req_if req_if ();
  saq_rsp_if rsp_if ();

  argsort_scoreboard sb = new(Cap);

  stable_argsort_queue_core #(.MAX_ITEMS(Cap)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Observe both handshakes at the edge; watch for a stalled block
  always @(posedge clk_i) begin
    if (req_if.valid && req_if.ready) sb.note_request(req_if.opcode, req_if.height);
    if (rsp_if.valid && rsp_if.ready)
      sb.check_result(rsp_if.orig_position, rsp_if.is_last, rsp_if.was_empty,
                      rsp_if.was_dropped);
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || !rst_ni)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before each result
  initial begin
    int unsigned stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  // Present one request after a random gap and hold it until taken
  task automatic send_request(logic op, logic [15:0] h);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.height <= h;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    if (op == saq_pkg::OpPush) begin
      if (gen_count < Cap) gen_count++;
    end else if (gen_count > 0) begin
      gen_count--;
    end
  endtask

  function automatic logic [15:0] pick_height();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3));
      1: return 16'(16'hFFFF - $urandom_range(0, 3));
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    int unsigned n;
    int unsigned pushes;
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.opcode = saq_pkg::OpPush;
    req_if.height = '0;
    no_idle       = 1'b0;
    quiet_cycles  = 0;
    gen_count     = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pop on empty, extreme and tied heights, drain
    send_request(saq_pkg::OpPop, 16'hFFFF);
    send_request(saq_pkg::OpPush, 16'h0000);
    send_request(saq_pkg::OpPush, 16'hFFFF);
    send_request(saq_pkg::OpPush, 16'h0000);
    send_request(saq_pkg::OpPush, 16'hAAAA);
    send_request(saq_pkg::OpPush, 16'h5555);
    repeat (5) send_request(saq_pkg::OpPop, 16'($urandom()));
    send_request(saq_pkg::OpPop, 16'h0000);
    n = 12;

    // Random small batches: fill then drain, with some extra pops
    while (n < 700) begin
      no_idle = ($urandom_range(0, 7) == 0);
      pushes = $urandom_range(1, 12);
      repeat (pushes) send_request(saq_pkg::OpPush, pick_height());
      n += pushes;
      while (gen_count > 0) begin
        if ($urandom_range(0, 5) == 0) send_request(saq_pkg::OpPush, pick_height());
        else send_request(saq_pkg::OpPop, 16'($urandom()));
        n++;
      end
      if ($urandom_range(0, 3) == 0) begin
        send_request(saq_pkg::OpPop, 16'($urandom()));
        n++;
      end
    end

    // Fill the store, then push into the full store
    no_idle = ($urandom_range(0, 1) == 0);
    while (gen_count < Cap) begin
      send_request(saq_pkg::OpPush, pick_height());
      n++;
    end
    repeat (3) begin
      send_request(saq_pkg::OpPush, pick_height());
      n++;
    end

    // Mixed traffic near capacity; the store never empties here
    no_idle = 1'b0;
    while (n < 1900) begin
      if ($urandom_range(0, 2) == 0) send_request(saq_pkg::OpPush, pick_height());
      else send_request(saq_pkg::OpPop, 16'($urandom()));
      n++;
    end

    req_if.valid <= 1'b0;
    no_idle = 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
